@@ sv/ectc_pkg.sv @@
// ----------------------------------------------------------------------------
// ectc_pkg
// Shared widths, constants, micro-op codes and the micro-program table for
// the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ectc_pkg;

    // input width and the widths that follow from it
    localparam int SECONDS_BITS = 38;

    localparam longint unsigned SECS_PER_DAY    = 64'd86400;
    localparam longint unsigned SECS_PER_HOUR   = 64'd3600;
    localparam longint unsigned SECS_PER_MIN    = 64'd60;
    localparam longint unsigned DAYS_PER_CYCLE  = 64'd146097;
    localparam longint unsigned YEARS_PER_CYCLE = 64'd400;
    localparam longint unsigned BASE_YEAR       = 64'd1970;
    localparam longint unsigned BASE_YMOD       = BASE_YEAR % YEARS_PER_CYCLE;

    // seconds in a common year, a leap year and a whole 400-year cycle
    localparam longint unsigned SECS_PER_YEAR      = 64'd365 * SECS_PER_DAY;
    localparam longint unsigned SECS_PER_LEAP_YEAR = 64'd366 * SECS_PER_DAY;
    localparam longint unsigned SECS_PER_CYCLE     = DAYS_PER_CYCLE * SECS_PER_DAY;

    localparam longint unsigned SECS_MAX = (64'd1 << SECONDS_BITS) - 64'd1;
    localparam longint unsigned DAYS_MAX = SECS_MAX / SECS_PER_DAY;
    localparam longint unsigned YEAR_MAX = BASE_YEAR + DAYS_MAX / 64'd365 + 64'd1;

    // accumulator holds the input and every constant it is compared against
    localparam int CYCLE_BITS    = $clog2(SECS_PER_CYCLE + 64'd1);
    localparam int ACC_BITS      = (SECONDS_BITS > CYCLE_BITS) ? SECONDS_BITS : CYCLE_BITS;
    localparam int YEAR_BITS_MIN = $clog2(YEAR_MAX + 64'd1);
    localparam int YMOD_BITS     = 9;

    // result field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int YEAR_BITS = (YEAR_BITS_MIN > YEAR_W) ? YEAR_BITS_MIN : YEAR_W;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // micro-op codes
    typedef enum logic {
        OP_SUB  = 1'b0,   // subtract constant and bump a counter while it fits
        OP_DONE = 1'b1    // hand the result to the output register
    } t_op;

    typedef enum logic [2:0] {
        K_DAY   = 3'd0,
        K_HOUR  = 3'd1,
        K_MIN   = 3'd2,
        K_CYCLE = 3'd3,
        K_YEAR  = 3'd4,
        K_MONTH = 3'd5
    } t_ksel;

    typedef enum logic [2:0] {
        D_NONE  = 3'd0,
        D_HOUR  = 3'd1,
        D_MIN   = 3'd2,
        D_CYCLE = 3'd3,
        D_YEAR  = 3'd4,
        D_MONTH = 3'd5,
        D_DAY   = 3'd6
    } t_dst;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_CYCLE = 3'd0;
    localparam t_pc PC_YEAR  = 3'd1;
    localparam t_pc PC_MONTH = 3'd2;
    localparam t_pc PC_DAY   = 3'd3;
    localparam t_pc PC_HOUR  = 3'd4;
    localparam t_pc PC_MIN   = 3'd5;
    localparam t_pc PC_DONE  = 3'd6;

    typedef struct packed {
        t_op   op;
        t_ksel ksel;
        t_dst  dst;
        t_pc   jmp;
    } t_uword;

    typedef struct packed {
        logic take;       // accumulator holds at least the selected constant
    } t_dp_status;

    // micro-program: looping steps jump to themselves while their condition holds
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_CYCLE: w = '{op: OP_SUB,  ksel: K_CYCLE, dst: D_CYCLE, jmp: PC_CYCLE};
            PC_YEAR:  w = '{op: OP_SUB,  ksel: K_YEAR,  dst: D_YEAR,  jmp: PC_YEAR};
            PC_MONTH: w = '{op: OP_SUB,  ksel: K_MONTH, dst: D_MONTH, jmp: PC_MONTH};
            PC_DAY:   w = '{op: OP_SUB,  ksel: K_DAY,   dst: D_DAY,   jmp: PC_DAY};
            PC_HOUR:  w = '{op: OP_SUB,  ksel: K_HOUR,  dst: D_HOUR,  jmp: PC_HOUR};
            PC_MIN:   w = '{op: OP_SUB,  ksel: K_MIN,   dst: D_MIN,   jmp: PC_MIN};
            default:  w = '{op: OP_DONE, ksel: K_DAY,   dst: D_NONE,  jmp: PC_DONE};
        endcase
        return w;
    endfunction

    // leap test on the year modulo 400
    function automatic logic is_leap(input logic [YMOD_BITS-1:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] days_of_month(input logic [MONTH_W-1:0] month,
                                                       input logic leap);
        logic [DAY_W-1:0] d;
        case (month)
            MONTH_FEB: d = leap ? 5'd29 : 5'd28;
            MONTH_APR: d = 5'd30;
            MONTH_JUN: d = 5'd30;
            MONTH_SEP: d = 5'd30;
            MONTH_NOV: d = 5'd30;
            default:   d = 5'd31;
        endcase
        return d;
    endfunction

    // seconds in a month of the given length
    function automatic logic [ACC_BITS-1:0] month_secs(input logic [DAY_W-1:0] days);
        logic [ACC_BITS-1:0] s;
        case (days)
            5'd28:   s = ACC_BITS'(64'd28 * SECS_PER_DAY);
            5'd29:   s = ACC_BITS'(64'd29 * SECS_PER_DAY);
            5'd30:   s = ACC_BITS'(64'd30 * SECS_PER_DAY);
            default: s = ACC_BITS'(64'd31 * SECS_PER_DAY);
        endcase
        return s;
    endfunction

endpackage

@@ sv/epoch_seconds_to_calendar_unit.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts seconds since 1970-01-01 00:00:00 to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// steps: 400-year cycles, years into the cycle, months, days, hours and
//   minutes are each walked by repeated subtraction from input accept; the
//   result then waits in the done step until the output register is free
// occupancy: one item in flight at a time, all steps share one subtractor
// reset: synchronous active-low, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ectc_pkg::SECONDS_BITS-1:0]   i_epoch_seconds,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ectc_pkg::YEAR_W-1:0]         o_year,
    output logic [ectc_pkg::MONTH_W-1:0]        o_month,
    output logic [ectc_pkg::DAY_W-1:0]          o_day_of_month,
    output logic [ectc_pkg::HOUR_W-1:0]         o_hour,
    output logic [ectc_pkg::MIN_W-1:0]          o_minute,
    output logic [ectc_pkg::SEC_W-1:0]          o_second
);
    import ectc_pkg::*;

    // sequencer state
    logic r_busy,      n_busy;
    t_pc  r_pc,        n_pc;
    logic r_out_valid, n_out_valid;

    // output register
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_min;
    logic [SEC_W-1:0]   r_sec;

    t_uword     w_uword;
    t_dp_status w_status;
    logic       in_fire;
    logic       run;
    logic       done;

    logic [YEAR_BITS-1:0] dp_year;
    logic [MONTH_W-1:0]   dp_month;
    logic [DAY_W-1:0]     dp_day;
    logic [HOUR_W-1:0]    dp_hour;
    logic [MIN_W-1:0]     dp_min;
    logic [SEC_W-1:0]     dp_sec;

    // micro-word for the current step
    assign w_uword = ucode(r_pc);

    // one item in flight; the output register lets a new item start while
    // the previous result still waits downstream
    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && !r_busy;
    assign run        = r_busy && (w_uword.op != OP_DONE);
    assign done       = r_busy && (w_uword.op == OP_DONE)
                        && (!r_out_valid || i_out_ready);

    ectc_dp u_dp (
        .i_clk           (i_clk),
        .i_load          (in_fire),
        .i_epoch_seconds (i_epoch_seconds),
        .i_run           (run),
        .i_uword         (w_uword),
        .o_status        (w_status),
        .o_year          (dp_year),
        .o_month         (dp_month),
        .o_day_of_month  (dp_day),
        .o_hour          (dp_hour),
        .o_minute        (dp_min),
        .o_second        (dp_sec)
    );

    // step counter with conditional jumps: each subtract step loops while
    // its constant still fits, then falls through to the next step
    always_comb begin
        n_pc        = r_pc;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        if (in_fire) begin
            n_pc   = PC_CYCLE;
            n_busy = 1'b1;
        end else if (run) begin
            case (w_uword.op)
                OP_SUB:  n_pc = w_status.take ? w_uword.jmp : r_pc + t_pc'(1);
                default: n_pc = r_pc + t_pc'(1);
            endcase
        end
        if (done) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_CYCLE;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // result capture, year keeps its low field bits
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_year  <= dp_year[YEAR_W-1:0];
            r_month <= dp_month;
            r_day   <= dp_day;
            r_hour  <= dp_hour;
            r_min   <= dp_min;
            r_sec   <= dp_sec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_day;
    assign o_hour         = r_hour;
    assign o_minute       = r_min;
    assign o_second       = r_sec;

    // a new item always starts at the 400-year cycle step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_busy && (r_pc == PC_CYCLE)))
        else $error("item did not start at cycle step");

    // a finished result never overwrites one still waiting downstream
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pc == PC_DONE) && r_out_valid && !i_out_ready)
        |=> (r_busy && (r_pc == PC_DONE) && r_out_valid))
        else $error("result lost while output stalled");

    // delivered date and time stay in their calendar ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_month >= MONTH_JAN) && (o_month <= MONTH_DEC)
                         && (o_day_of_month != '0) && (o_hour <= 5'd23)
                         && (o_minute <= 6'd59) && (o_second <= 6'd59)))
        else $error("calendar field out of range");

endmodule

@@ sv/ectc_dp.sv @@
// ----------------------------------------------------------------------------
// ectc_dp
// Datapath of the converter: seconds accumulator, one shared compare and
// subtract and the calendar counters, driven by a micro-word.
// ----------------------------------------------------------------------------
module ectc_dp (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [ectc_pkg::SECONDS_BITS-1:0]   i_epoch_seconds,
    input  logic                                i_run,
    input  ectc_pkg::t_uword                    i_uword,
    output ectc_pkg::t_dp_status                o_status,
    output logic [ectc_pkg::YEAR_BITS-1:0]      o_year,
    output logic [ectc_pkg::MONTH_W-1:0]        o_month,
    output logic [ectc_pkg::DAY_W-1:0]          o_day_of_month,
    output logic [ectc_pkg::HOUR_W-1:0]         o_hour,
    output logic [ectc_pkg::MIN_W-1:0]          o_minute,
    output logic [ectc_pkg::SEC_W-1:0]          o_second
);
    import ectc_pkg::*;

    logic [ACC_BITS-1:0]     r_acc,   n_acc;
    logic [YEAR_BITS-1:0]    r_year,  n_year;
    logic [YMOD_BITS-1:0]    r_ymod,  n_ymod;
    logic [MONTH_W-1:0]      r_month, n_month;
    logic [DAY_W-1:0]        r_day,   n_day;
    logic [HOUR_W-1:0]       r_hour,  n_hour;
    logic [MIN_W-1:0]        r_min,   n_min;

    logic                leap;
    logic [ACC_BITS-1:0] k;
    logic                sub_ge;
    logic                month_end;

    always_comb begin
        leap = is_leap(r_ymod);
        case (i_uword.ksel)
            K_HOUR:  k = ACC_BITS'(SECS_PER_HOUR);
            K_MIN:   k = ACC_BITS'(SECS_PER_MIN);
            K_CYCLE: k = ACC_BITS'(SECS_PER_CYCLE);
            K_YEAR:  k = leap ? ACC_BITS'(SECS_PER_LEAP_YEAR) : ACC_BITS'(SECS_PER_YEAR);
            K_MONTH: k = month_secs(days_of_month(r_month, leap));
            default: k = ACC_BITS'(SECS_PER_DAY);
        endcase

        sub_ge = (r_acc >= k);
        // december takes whatever is left
        month_end = (i_uword.dst == D_MONTH) && (r_month == MONTH_DEC);

        o_status.take = sub_ge && !month_end;
    end

    always_comb begin
        n_acc   = r_acc;
        n_year  = r_year;
        n_ymod  = r_ymod;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        if (i_load) begin
            n_acc   = ACC_BITS'(i_epoch_seconds);
            n_year  = YEAR_BITS'(BASE_YEAR);
            n_ymod  = YMOD_BITS'(BASE_YMOD);
            n_month = MONTH_JAN;
            n_day   = DAY_W'(1);
            n_hour  = '0;
            n_min   = '0;
        end else if (i_run) begin
            case (i_uword.op)
                OP_SUB: begin
                    if (o_status.take) begin
                        n_acc = r_acc - k;
                        case (i_uword.dst)
                            D_HOUR:  n_hour = r_hour + HOUR_W'(1);
                            D_MIN:   n_min  = r_min + MIN_W'(1);
                            D_CYCLE: n_year = r_year + YEAR_BITS'(YEARS_PER_CYCLE);
                            D_YEAR: begin
                                n_year = r_year + YEAR_BITS'(1);
                                n_ymod = (r_ymod == YMOD_BITS'(YEARS_PER_CYCLE - 1)) ?
                                         '0 : r_ymod + YMOD_BITS'(1);
                            end
                            D_MONTH: n_month = r_month + MONTH_W'(1);
                            D_DAY:   n_day   = r_day + DAY_W'(1);
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_year  <= n_year;
        r_ymod  <= n_ymod;
        r_month <= n_month;
        r_day   <= n_day;
        r_hour  <= n_hour;
        r_min   <= n_min;
    end

    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_day;
    assign o_hour         = r_hour;
    assign o_minute       = r_min;
    // what is left after the minute walk is the second
    assign o_second       = r_acc[SEC_W-1:0];

endmodule
